// ----- hdl/sfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

    localparam int CMD_W   = 2;
    localparam int REQ_W   = 14;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 12;
    localparam int AVAIL_W = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_IN   = 2'd2,
        ST_LIST_FULL = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] address;
    } t_in_word;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ADDR_W-1:0]  address_res;
        logic [CNT_W-1:0]   object_count;
        logic [AVAIL_W-1:0] bytes_available;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLASS,
        S_ENTRY_RD,
        S_SIZE_RD,
        S_CHECK,
        S_SHIFT,
        S_TAKE,
        S_BUMP,
        S_FREE_RD,
        S_FREE_PUSH,
        S_CLEAR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic class_init;
        logic class_load;
        logic class_next;
        logic entry_rd;
        logic size_rd;
        logic entry_next;
        logic shift_step;
        logic take;
        logic bump;
        logic free_rd;
        logic free_push;
        logic clear;
        logic finish;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic class_end;
        logic class_empty;
        logic list_empty;
        logic fits;
        logic shift_done;
        logic bump_ok;
        logic free_ok;
        logic clear_ok;
    } t_sts;

endpackage
`default_nettype wire

// ----- hdl/sfa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfa_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire sfa_pkg::t_sts i_sts,
    output sfa_pkg::t_ctl    o_ctl,
    output logic             o_busy
);
    import sfa_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_start) n_state = S_DECODE;
            S_DECODE: begin
                case (i_sts.cmd)
                    CMD_ALLOC: n_state = S_CLASS;
                    CMD_FREE:  n_state = i_sts.free_ok ? S_FREE_RD : S_FINISH;
                    CMD_CLEAR: n_state = S_CLEAR;
                    default:   n_state = S_FINISH;
                endcase
            end
            S_CLASS: begin
                if (i_sts.class_end)        n_state = S_BUMP;
                else if (i_sts.class_empty) n_state = S_CLASS;
                else                        n_state = S_ENTRY_RD;
            end
            S_ENTRY_RD:  n_state = S_SIZE_RD;
            S_SIZE_RD:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.fits)            n_state = S_SHIFT;
                else if (i_sts.list_empty) n_state = S_CLASS;
                else                       n_state = S_ENTRY_RD;
            end
            S_SHIFT:     if (i_sts.shift_done) n_state = S_TAKE;
            S_TAKE:      n_state = S_FINISH;
            S_BUMP:      n_state = S_FINISH;
            S_FREE_RD:   n_state = S_FREE_PUSH;
            S_FREE_PUSH: n_state = S_FINISH;
            S_CLEAR:     n_state = S_FINISH;
            S_FINISH:    n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        case (r_state)
            S_IDLE:      o_ctl.load = i_start;
            S_DECODE:    o_ctl.class_init = 1'b1;
            S_CLASS:     o_ctl.class_load = 1'b1;
            S_ENTRY_RD:  o_ctl.entry_rd = 1'b1;
            S_SIZE_RD:   o_ctl.size_rd = 1'b1;
            S_CHECK:     o_ctl.entry_next = 1'b1;
            S_SHIFT:     o_ctl.shift_step = 1'b1;
            S_TAKE:      o_ctl.take = 1'b1;
            S_BUMP:      o_ctl.bump = 1'b1;
            S_FREE_RD:   o_ctl.free_rd = 1'b1;
            S_FREE_PUSH: o_ctl.free_push = 1'b1;
            S_CLEAR:     o_ctl.clear = 1'b1;
            S_FINISH:    o_ctl.finish = 1'b1;
            default:     o_ctl = '0;
        endcase
        o_busy = (r_state != S_IDLE);
    end
endmodule
`default_nettype wire

// ----- hdl/sfa_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfa_dp #(
    parameter int ARENA_MAX_BYTES = 16384,
    parameter int NUM_CLASSES     = 15,
    parameter int LIST_DEPTH      = 16,
    parameter int HEADER_BYTES    = 20
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire sfa_pkg::t_in_word            i_word,
    input  wire logic                         i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire sfa_pkg::t_ctl                i_ctl,
    output sfa_pkg::t_sts                     o_sts,
    output logic                              o_done,
    output sfa_pkg::t_out_word                o_word
);
    import sfa_pkg::*;

    localparam int WORDS  = ARENA_MAX_BYTES / 4;
    localparam int OFF_W  = $clog2(ARENA_MAX_BYTES + 1);
    localparam int WA_W   = $clog2(WORDS);
    localparam int CLS_W  = $clog2(NUM_CLASSES + 1);
    localparam int CI_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int LI_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int ENT    = NUM_CLASSES * LIST_DEPTH;
    localparam int EA_W   = (ENT > 1) ? $clog2(ENT) : 1;
    localparam int SZ_W   = 15;
    localparam int BIG_W  = 34;
    localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;

    logic [ADDR_W-1:0]  r_base;
    logic [AVAIL_W-1:0] r_abytes;
    logic [OFF_W-1:0]   r_bump;
    logic [CNT_W-1:0]   r_live;
    logic [AVAIL_W-1:0] r_listed;
    logic [LEN_W-1:0]   r_len [NUM_CLASSES];

    logic [OFF_W-1:0]   r_ent_mem  [ENT];
    logic [SZ_W-1:0]    r_size_mem [WORDS];

    t_in_word           r_in;
    logic [BIG_W-1:0]   r_need;
    logic [CLS_W-1:0]   r_cls;
    logic [LEN_W-1:0]   r_j;
    logic [LEN_W-1:0]   r_clen;
    logic [OFF_W-1:0]   r_chunk;
    logic [SZ_W-1:0]    r_sz;
    logic [OFF_W-1:0]   r_shv;
    logic               r_shrd;
    logic [1:0]         r_stat;
    logic [ADDR_W-1:0]  r_res;
    logic [BIG_W-1:0]   r_eff;
    logic [ADDR_W-1:0]  r_off;
    logic               r_done;
    t_out_word          r_out;

    function automatic logic [CLS_W-1:0] f_class(input logic [BIG_W-1:0] x);
        logic [CLS_W-1:0] c;
        c = '0;
        for (int i = 1; i < BIG_W; i++) begin
            if (x[i]) c = (i > NUM_CLASSES - 1) ? CLS_W'(NUM_CLASSES - 1) : CLS_W'(i);
        end
        return c;
    endfunction

    logic [BIG_W-1:0] w_eff;
    logic [ADDR_W-1:0] w_off;
    always_comb begin
        w_eff = (BIG_W'(r_abytes) > BIG_W'(ARENA_MAX_BYTES))
              ? BIG_W'(ARENA_MAX_BYTES) : BIG_W'(r_abytes);
        w_off = i_word.address - r_base;
    end

    logic [CI_W-1:0] w_ci;
    logic [EA_W-1:0] w_ent_rd, w_ent_wr;
    logic [BIG_W-1:0] w_avail;
    logic [BIG_W-1:0] w_unb;
    logic [CLS_W-1:0] w_fcls;
    logic [CI_W-1:0]  w_fci;
    assign w_ci   = CI_W'(r_cls);
    assign w_fcls = f_class(BIG_W'(r_sz));
    assign w_fci  = CI_W'(w_fcls);

    always_comb begin
        w_unb   = (w_eff > BIG_W'(r_bump)) ? w_eff - BIG_W'(r_bump) : '0;
        w_avail = w_unb + BIG_W'(r_listed);
    end

    always_comb begin
        o_sts.cmd         = t_cmd'(r_in.command);
        o_sts.class_end   = (r_cls >= CLS_W'(NUM_CLASSES));
        o_sts.class_empty = (r_len[w_ci] == '0);
        o_sts.list_empty  = (r_j == '0);
        o_sts.fits        = (BIG_W'(r_sz) >= r_need);
        o_sts.shift_done  = (r_j + LEN_W'(1) >= r_clen) && !r_shrd;
        o_sts.bump_ok     = (BIG_W'(r_bump) + r_need <= r_eff);
        o_sts.free_ok     = (BIG_W'(r_off) < r_eff)
                          && (r_off >= ADDR_W'(HEADER_BYTES + 4));
        o_sts.clear_ok    = (BIG_W'(r_off) < r_eff);
    end

    // entry memory address
    logic [LI_W-1:0] w_jidx;
    assign w_jidx = LI_W'(r_j);
    always_comb begin
        w_ent_rd = EA_W'(w_ci) * EA_W'(LIST_DEPTH) + EA_W'(w_jidx);
        w_ent_wr = EA_W'(w_fci) * EA_W'(LIST_DEPTH) + EA_W'(LI_W'(r_len[w_fci]));
    end

    logic [OFF_W-1:0] w_fchunk;
    assign w_fchunk = OFF_W'(r_off - ADDR_W'(4));

    // entry memory: shift uses read at j+1, write at j
    logic [EA_W-1:0] w_ent_nx;
    assign w_ent_nx = w_ent_rd + EA_W'(1);
    always_ff @(posedge i_clk) begin
        if (i_ctl.entry_rd) begin
            r_chunk <= r_ent_mem[w_ent_rd];
        end else if (i_ctl.free_rd) begin
            r_chunk <= w_fchunk;
        end
        if (i_ctl.shift_step && !o_sts.shift_done) begin
            if (r_shrd) r_shv <= r_ent_mem[w_ent_nx];
            else        r_ent_mem[w_ent_rd] <= r_shv;
        end
        if (i_ctl.free_push && o_sts.free_ok && (r_len[w_fci] < LEN_W'(LIST_DEPTH))) begin
            r_ent_mem[w_ent_wr] <= r_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.size_rd) begin
            r_sz <= r_size_mem[WA_W'(r_chunk >> 2)];
        end else if (i_ctl.free_rd) begin
            r_sz <= r_size_mem[WA_W'(w_fchunk >> 2)];
        end
        if (i_ctl.bump && o_sts.bump_ok) begin
            r_size_mem[WA_W'(r_bump >> 2)] <= SZ_W'(r_need);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= '0;
            r_abytes <= AVAIL_W'(1024);
            r_bump   <= OFF_W'(HEADER_BYTES);
            r_live   <= '0;
            r_listed <= '0;
            r_done   <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) r_len[i] <= '0;
        end else begin
            r_done <= i_ctl.finish;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BASE) r_base <= i_cfg_data;
                else                       r_abytes <= AVAIL_W'(i_cfg_data);
            end
            if (i_ctl.load) begin
                r_in   <= i_word;
                r_need <= (BIG_W'(4) + BIG_W'(i_word.request_bytes) + BIG_W'(3))
                          & ~BIG_W'(3);
                r_eff  <= w_eff;
                r_off  <= w_off;
                r_stat <= ST_OK;
                r_res  <= '0;
            end
            if (i_ctl.class_init) begin
                r_cls <= f_class(r_need);
                r_j   <= '0;
                if (o_sts.cmd == CMD_FREE && !o_sts.free_ok) r_stat <= ST_NOT_IN;
            end
            if (i_ctl.class_load && !o_sts.class_end) begin
                if (o_sts.class_empty) begin
                    r_cls <= r_cls + CLS_W'(1);
                end else begin
                    r_clen <= r_len[w_ci];
                    r_j    <= r_len[w_ci] - LEN_W'(1);
                    r_shrd <= 1'b0;
                end
            end
            if (i_ctl.entry_next) begin
                if (o_sts.fits) begin
                    r_shrd <= 1'b1;
                end else if (r_j == '0) begin
                    r_cls <= r_cls + CLS_W'(1);
                end else begin
                    r_j <= r_j - LEN_W'(1);
                end
            end
            if (i_ctl.shift_step && !o_sts.shift_done) begin
                r_shrd <= !r_shrd;
                if (!r_shrd) r_j <= r_j + LEN_W'(1);
            end
            if (i_ctl.take) begin
                r_len[w_ci] <= r_clen - LEN_W'(1);
                r_listed    <= (r_listed > AVAIL_W'(r_sz)) ? r_listed - AVAIL_W'(r_sz) : '0;
                r_res       <= r_base + ADDR_W'(r_chunk) + ADDR_W'(4);
                r_live      <= r_live + CNT_W'(1);
            end
            if (i_ctl.bump) begin
                if (o_sts.bump_ok) begin
                    r_res  <= r_base + ADDR_W'(r_bump) + ADDR_W'(4);
                    r_bump <= r_bump + OFF_W'(r_need);
                    r_live <= r_live + CNT_W'(1);
                end else begin
                    r_stat <= ST_NO_SPACE;
                end
            end
            if (i_ctl.free_push) begin
                r_live <= r_live - CNT_W'(1);
                if (r_len[w_fci] >= LEN_W'(LIST_DEPTH)) begin
                    r_stat <= ST_LIST_FULL;
                end else begin
                    r_len[w_fci] <= r_len[w_fci] + LEN_W'(1);
                    r_listed <= ({1'b0, r_listed} + {1'b0, AVAIL_W'(r_sz)} > {1'b0, AVAIL_MAX})
                              ? AVAIL_MAX : r_listed + AVAIL_W'(r_sz);
                end
            end
            if (i_ctl.clear) begin
                if (o_sts.clear_ok) begin
                    for (int i = 0; i < NUM_CLASSES; i++) r_len[i] <= '0;
                    r_bump   <= OFF_W'(HEADER_BYTES);
                    r_live   <= '0;
                    r_listed <= '0;
                end else begin
                    r_stat <= ST_NOT_IN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out.status          <= r_stat;
            r_out.address_res     <= r_res;
            r_out.object_count    <= r_live;
            r_out.bytes_available <= (w_avail > BIG_W'(AVAIL_MAX)) ? AVAIL_MAX
                                                                  : AVAIL_W'(w_avail);
        end
    end

    assign o_done = r_done;
    assign o_word = r_out;
endmodule
`default_nettype wire

// ----- hdl/segregated_fit_arena_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Arena allocator with segregated free lists and a bump pointer. Pulse
// start while busy is low to issue a word; the result appears on o_result
// for one cycle with o_result_valid and cannot be stalled. An allocate walks
// size classes from the request's class upward, examining each list's
// entries from the last one down and shifting later entries down on removal;
// if no listed chunk fits, it takes a bump allocation.
// Configuration writes take effect at once and are legal only while idle.
module segregated_fit_arena_allocator_top #(
    parameter int ARENA_MAX_BYTES = 16384,
    parameter int NUM_CLASSES     = 15,
    parameter int LIST_DEPTH      = 16,
    parameter int HEADER_BYTES    = 20
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire sfa_pkg::t_in_word              i_word,
    output logic                                o_result_valid,
    output sfa_pkg::t_out_word                  o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfa_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    sfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    sfa_dp #(
        .ARENA_MAX_BYTES (ARENA_MAX_BYTES),
        .NUM_CLASSES     (NUM_CLASSES),
        .LIST_DEPTH      (LIST_DEPTH),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (i_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_done     (o_result_valid),
        .o_word     (o_result)
    );
endmodule
`default_nettype wire

// ----- hdl/sfa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfa_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_result_valid,
    input wire sfa_pkg::t_out_word o_result
);
    import sfa_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("result held");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy) else $error("result while busy");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_OK) |-> (o_result.address_res == '0))
        else $error("failed word carries address");
endmodule

bind segregated_fit_arena_allocator_top sfa_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
`default_nettype wire
